// ===== sv/msa_pkg.sv =====
`timescale 1ns / 1ps
package msa_pkg;

	// sizing of the stores
	localparam int MAX_SLOTS = 1024;
	localparam int MAX_IDS   = 1024;

	// fixed field widths
	localparam int CFG_W  = 11;
	localparam int ID_W   = 10;
	localparam int SEAT_W = 11;
	localparam int STAT_W = 2;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	// positions run up to n+1, n being num_slots clamped to 1024; num_slots is at most 2047
	localparam int POS_W  = CFG_W + 1;

	localparam int SLOT_AW = $clog2(MAX_SLOTS);
	localparam int ID_AW   = $clog2(MAX_IDS);
	localparam int CLR_N   = (MAX_SLOTS > MAX_IDS) ? MAX_SLOTS : MAX_IDS;
	localparam int CLR_AW  = $clog2(CLR_N);

	localparam logic [CFG_W-1:0] INF_CODE   = '1;
	localparam logic [CFG_W-1:0] DIST_MAX   = INF_CODE - CFG_W'(1);
	localparam logic [CFG_W-1:0] SLOTS_RST  = CFG_W'(1024);
	localparam logic [CFG_W-1:0] MINREQ_RST = '0;

	// request codes
	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_LEAVE  = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_SLOT  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNSEATED = 2'd2;

	// register index (paddr[2])
	localparam logic REG_NUM_SLOTS = 1'b0;
	localparam logic REG_MIN_REQ   = 1'b1;

	typedef struct packed {
		logic clear;
		logic accept;
		logic scan;
		logic commit;
		logic lv_chk;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic reject;
		logic is_leave;
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage

// ===== sv/max_gap_slot_allocator.sv =====
`timescale 1ns / 1ps
// max-gap slot allocator
// request channel: in_valid/in_ready with func (0 arrive, 1 leave) and id
// result channel: out_valid/out_ready, one word per request: position,
//   min_distance, infinite, meets_threshold, status (0 ok, 1 no free slot,
//   2 leave of unseated id)
// config: apb-style port, num_slots at 0x0, min_required at 0x4, pready tied high;
//   write only while no request is in flight
// reset: after arst_n releases, a clearing pass over 1024 addresses (larger of slot
//   and id table depths) zeroes the occupancy map and seat table; in_ready
//   stays low for that time, config writes are taken throughout
// arrive: scans the occupancy map slot by slot through its single read port,
//   n = min(num_slots, 1024) slots and the far wall, then commits;
//   leave reads the seat table then checks it; a rejected request skips both
// throughput: one request at a time; a new word is taken while the previous
//   result still sits in the output register
// stall: if out_ready is low the result holds; a second finished result waits in the
//   datapath result registers, the controller in its response state, until the output register frees
module max_gap_slot_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [msa_pkg::ADDR_W-1:0]  paddr,
	input  logic [msa_pkg::DATA_W-1:0]  pwdata,
	output logic [msa_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [msa_pkg::ID_W-1:0]    id,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [msa_pkg::CFG_W-1:0]   position,
	output logic [msa_pkg::CFG_W-1:0]   min_distance,
	output logic                        infinite,
	output logic                        meets_threshold,
	output logic [msa_pkg::STAT_W-1:0]  status
);
	import msa_pkg::*;

	logic [CFG_W-1:0] num_slots_q, min_req_q, rd_val;
	logic             cfg_wr;
	cmd_t             cmd;
	stat_t            st;

	// config registers, decoded by paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_slots_q <= SLOTS_RST;
			min_req_q   <= MINREQ_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_NUM_SLOTS: num_slots_q <= pwdata[CFG_W-1:0];
				REG_MIN_REQ:   min_req_q   <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			REG_NUM_SLOTS: rd_val = num_slots_q;
			REG_MIN_REQ:   rd_val = min_req_q;
			default:       rd_val = '0;
		endcase
	end
	assign prdata = DATA_W'(rd_val);

	// sequencer
	msa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// scan, tables, running minimum and result register
	msa_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.num_slots       (num_slots_q),
		.min_required    (min_req_q),
		.func            (func),
		.id              (id),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.position        (position),
		.min_distance    (min_distance),
		.infinite        (infinite),
		.meets_threshold (meets_threshold),
		.status          (status)
	);

`ifndef SYNTH
	// the block is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after accept");

	// a successful result always names a real slot
	a_ok_has_position: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_OK)) |-> (position != '0))
		else $error("ok result with position zero");

	// a result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("pending result dropped");
`endif

endmodule

// ===== sv/msa_ram.sv =====
`timescale 1ns / 1ps
module msa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/msa_ctrl.sv =====
`timescale 1ns / 1ps
module msa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  msa_pkg::stat_t st,
	output msa_pkg::cmd_t  cmd
);
	import msa_pkg::*;

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_COMMIT = 7'b0001000,
		ST_LV_RD  = 7'b0010000,
		ST_LV_CHK = 7'b0100000,
		ST_RESP   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (st.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					priority if (st.reject) state_d = ST_RESP;
					else if (st.is_leave) state_d = ST_LV_RD;
					else state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.scan_done) state_d = ST_COMMIT;
			end
			ST_COMMIT: state_d = ST_RESP;
			ST_LV_RD:  state_d = ST_LV_CHK;
			ST_LV_CHK: state_d = ST_RESP;
			ST_RESP: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign cmd.clear    = (state_q == ST_CLEAR);
	assign cmd.accept   = (state_q == ST_IDLE) && in_valid;
	assign cmd.scan     = (state_q == ST_SCAN);
	assign cmd.commit   = (state_q == ST_COMMIT);
	assign cmd.lv_chk   = (state_q == ST_LV_CHK);
	assign cmd.load_out = (state_q == ST_RESP) && st.out_free;

endmodule

// ===== sv/msa_dp.sv =====
`timescale 1ns / 1ps
module msa_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  msa_pkg::cmd_t                cmd,
	output msa_pkg::stat_t               st,
	input  logic [msa_pkg::CFG_W-1:0]    num_slots,
	input  logic [msa_pkg::CFG_W-1:0]    min_required,
	input  logic                         func,
	input  logic [msa_pkg::ID_W-1:0]     id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [msa_pkg::CFG_W-1:0]    position,
	output logic [msa_pkg::CFG_W-1:0]    min_distance,
	output logic                         infinite,
	output logic                         meets_threshold,
	output logic [msa_pkg::STAT_W-1:0]   status
);
	import msa_pkg::*;

	function automatic logic [CFG_W-1:0] dist_sat(input logic [POS_W-1:0] d);
		logic [CFG_W-1:0] r;
		r = (d > POS_W'(DIST_MAX)) ? DIST_MAX : d[CFG_W-1:0];
		return r;
	endfunction

	// row length and wall position
	logic [POS_W-1:0] n, n_p1;

	// request and scan state
	logic              func_q;
	logic [ID_W-1:0]   id_q;
	logic [POS_W-1:0]  p_q, ev_p_s1, last_q, bl_q, br_q;
	logic              ev_v_s1, wall_s1;
	logic [CFG_W-1:0]  best_q, rmin_q, res_pos_q;
	logic [STAT_W-1:0] res_stat_q;
	logic [CLR_AW-1:0] clr_q;

	// memories
	logic               occ_we, occ_wdata, occ_rdata;
	logic [SLOT_AW-1:0] occ_waddr, occ_raddr;
	logic               seat_we;
	logic [ID_AW-1:0]   seat_addr;
	logic [SEAT_W-1:0]  seat_wdata, seat_rdata;

	// scan evaluation
	logic             issue, hit, better;
	logic [POS_W-1:0] gap;
	logic [CFG_W-1:0] half;

	// commit math
	logic [POS_W:0]   mid_sum;
	logic [POS_W-1:0] mid;
	logic [CFG_W-1:0] dl, dr, min1, min2;
	logic             commit_ok, seat_ok, rmin_inf;

	assign n    = (32'(num_slots) > MAX_SLOTS) ? POS_W'(MAX_SLOTS) : POS_W'(num_slots);
	assign n_p1 = n + POS_W'(1);

	assign issue = cmd.scan && (p_q <= n_p1);
	assign hit   = ev_v_s1 && (wall_s1 || occ_rdata);
	assign gap   = ev_p_s1 - last_q;
	assign half  = gap[POS_W-1:1];
	assign better = hit && (half > best_q);

	assign mid_sum   = {1'b0, bl_q} + {1'b0, br_q};
	assign mid       = mid_sum[POS_W:1];
	assign dl        = dist_sat(mid - bl_q);
	assign dr        = dist_sat(br_q - mid);
	assign min1      = ((bl_q != '0) && (dl < rmin_q)) ? dl : rmin_q;
	assign min2      = ((br_q != n_p1) && (dr < min1)) ? dr : min1;
	assign commit_ok = (best_q != '0);

	assign seat_ok = (seat_rdata != '0) && (32'(seat_rdata) <= MAX_SLOTS);

	// occupancy map port
	assign occ_raddr = SLOT_AW'(p_q - POS_W'(1));
	always_comb begin
		occ_we    = 1'b0;
		occ_waddr = SLOT_AW'(clr_q);
		occ_wdata = 1'b0;
		priority if (cmd.clear) begin
			occ_we = (32'(clr_q) < MAX_SLOTS);
		end else if (cmd.commit && commit_ok) begin
			occ_we    = 1'b1;
			occ_waddr = SLOT_AW'(mid - POS_W'(1));
			occ_wdata = 1'b1;
		end else if (cmd.lv_chk && seat_ok) begin
			occ_we    = 1'b1;
			occ_waddr = SLOT_AW'(seat_rdata - SEAT_W'(1));
		end
	end

	// seat table port
	always_comb begin
		seat_we    = 1'b0;
		seat_addr  = ID_AW'(id_q);
		seat_wdata = '0;
		priority if (cmd.clear) begin
			seat_we   = (32'(clr_q) < MAX_IDS);
			seat_addr = ID_AW'(clr_q);
		end else if (cmd.commit && commit_ok) begin
			seat_we    = 1'b1;
			seat_wdata = SEAT_W'(mid);
		end else if (cmd.lv_chk && seat_ok) begin
			seat_we = 1'b1;
		end
	end

	msa_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_occ (
		.clk   (clk),
		.we    (occ_we),
		.waddr (occ_waddr),
		.wdata (occ_wdata),
		.raddr (occ_raddr),
		.rdata (occ_rdata)
	);

	msa_ram #(.WIDTH(SEAT_W), .DEPTH(MAX_IDS)) u_seat (
		.clk   (clk),
		.we    (seat_we),
		.waddr (seat_addr),
		.wdata (seat_wdata),
		.raddr (seat_addr),
		.rdata (seat_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			ev_v_s1   <= 1'b0;
			rmin_q    <= INF_CODE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + CLR_AW'(1);
			ev_v_s1 <= issue;
			if (cmd.commit && commit_ok) rmin_q <= min2;
			if (cmd.load_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q     <= func;
			id_q       <= id;
			p_q        <= POS_W'(1);
			last_q     <= '0;
			best_q     <= '0;
			bl_q       <= '0;
			br_q       <= '0;
			res_pos_q  <= '0;
			res_stat_q <= (func == FUNC_LEAVE) ? STAT_UNSEATED : STAT_NO_SLOT;
		end else begin
			if (issue) p_q <= p_q + POS_W'(1);
			if (hit) last_q <= ev_p_s1;
			if (better) begin
				best_q <= half;
				bl_q   <= last_q;
				br_q   <= ev_p_s1;
			end
			if (cmd.commit && commit_ok) begin
				res_pos_q  <= CFG_W'(mid);
				res_stat_q <= STAT_OK;
			end
			if (cmd.lv_chk && seat_ok) begin
				res_pos_q  <= seat_rdata;
				res_stat_q <= STAT_OK;
			end
		end
		ev_p_s1 <= p_q;
		wall_s1 <= (p_q == n_p1);
		if (cmd.load_out) begin
			position        <= res_pos_q;
			min_distance    <= rmin_inf ? '0 : rmin_q;
			infinite        <= rmin_inf;
			meets_threshold <= rmin_inf || (rmin_q >= min_required);
			status          <= res_stat_q;
		end
	end

	assign rmin_inf = (rmin_q == INF_CODE);

	assign st.clear_last = cmd.clear && (clr_q == CLR_AW'(CLR_N - 1));
	assign st.reject     = (32'(id) >= MAX_IDS) || ((func == FUNC_ARRIVE) && (n == '0));
	assign st.is_leave   = (func == FUNC_LEAVE);
	assign st.scan_done  = ev_v_s1 && wall_s1 && !func_q;
	assign st.out_free   = !out_valid || out_ready;

endmodule

// ===== verif/max_gap_slot_allocator_checker.sv =====
`timescale 1ns / 1ps
module max_gap_slot_allocator_checker
	import msa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	input  logic                pready,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                func,
	input  logic [ID_W-1:0]     id,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [CFG_W-1:0]    position,
	input  logic [CFG_W-1:0]    min_distance,
	input  logic                infinite,
	input  logic                meets_threshold,
	input  logic [STAT_W-1:0]   status,
	output int                  errors,
	output int                  outstanding
);

	typedef struct packed {
		logic [CFG_W-1:0]  position;
		logic [CFG_W-1:0]  min_distance;
		logic              infinite;
		logic              meets;
		logic [STAT_W-1:0] status;
	} answer_t;

	// shadow of the row, the seat table and the registers
	logic              occupied [0:MAX_SLOTS+1];
	logic [SEAT_W-1:0] seat_of  [0:MAX_IDS-1];
	logic [CFG_W-1:0]  closest;
	logic [CFG_W-1:0]  row_slots;
	logic [CFG_W-1:0]  threshold;

	answer_t answers_due [$];

	task automatic flag_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 40) begin
			$display("%0t ns: %s got %0d want %0d", $time, what, got, want);
		end
	endtask

	function automatic void tighten(input int span);
		if (span > int'(DIST_MAX)) begin
			span = int'(DIST_MAX);
		end
		if (span < int'(closest)) begin
			closest = CFG_W'(span);
		end
	endfunction

	function automatic answer_t serve_request(input logic f, input logic [ID_W-1:0] rid);
		answer_t ans;
		int n, last, best, lo, hi, p, half, mid;
		logic [SEAT_W-1:0] seat;
		n = (int'(row_slots) > MAX_SLOTS) ? MAX_SLOTS : int'(row_slots);
		ans.position = '0;
		ans.status = STAT_OK;
		if (f == FUNC_ARRIVE) begin
			last = 0;
			best = 0;
			lo = 0;
			hi = 0;
			// widest half-gap wins, leftmost on a tie
			for (p = 1; p <= n + 1; p++) begin
				if (p == n + 1 || occupied[p]) begin
					half = (p - last) / 2;
					if (half > best) begin
						best = half;
						lo = last;
						hi = p;
					end
					last = p;
				end
			end
			if (n == 0 || best == 0) begin
				ans.status = STAT_NO_SLOT;
			end else begin
				mid = (lo + hi) / 2;
				// walls never count as neighbours
				if (lo != 0) begin
					tighten(mid - lo);
				end
				if (hi != n + 1) begin
					tighten(hi - mid);
				end
				occupied[mid] = 1'b1;
				seat_of[rid] = SEAT_W'(mid);
				ans.position = CFG_W'(mid);
			end
		end else begin
			seat = seat_of[rid];
			if (seat == '0 || int'(seat) > MAX_SLOTS) begin
				ans.status = STAT_UNSEATED;
			end else begin
				occupied[seat] = 1'b0;
				seat_of[rid] = '0;
				ans.position = CFG_W'(seat);
			end
		end
		ans.infinite = (closest == INF_CODE);
		ans.min_distance = ans.infinite ? '0 : closest;
		ans.meets = ans.infinite || (closest >= threshold);
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			for (int i = 0; i <= MAX_SLOTS + 1; i++) begin
				occupied[i] = 1'b0;
			end
			for (int i = 0; i < MAX_IDS; i++) begin
				seat_of[i] = '0;
			end
			closest = INF_CODE;
			row_slots = SLOTS_RST;
			threshold = MINREQ_RST;
			answers_due.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[ADDR_W-1:2] == REG_NUM_SLOTS) begin
					row_slots = pwdata[CFG_W-1:0];
				end else if (paddr[ADDR_W-1:2] == REG_MIN_REQ) begin
					threshold = pwdata[CFG_W-1:0];
				end
			end
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					flag_mismatch("word with nothing expected, position", position, 0);
				end else begin
					want = answers_due.pop_front();
					if (position !== want.position) begin
						flag_mismatch("position", position, want.position);
					end
					if (min_distance !== want.min_distance) begin
						flag_mismatch("min_distance", min_distance, want.min_distance);
					end
					if (infinite !== want.infinite) begin
						flag_mismatch("infinite", infinite, want.infinite);
					end
					if (meets_threshold !== want.meets) begin
						flag_mismatch("meets_threshold", meets_threshold, want.meets);
					end
					if (status !== want.status) begin
						flag_mismatch("status", status, want.status);
					end
				end
			end
			if (in_valid && in_ready) begin
				answers_due.push_back(serve_request(func, id));
			end
			outstanding <= answers_due.size();
		end
	end

endmodule

// ===== verif/max_gap_slot_allocator_test.sv =====
`timescale 1ns / 1ps
module max_gap_slot_allocator_test;
	import msa_pkg::*;

	// run limits, in clock cycles
	localparam int LIMIT       = 1000000;
	localparam int HOLD_CYCLES = 3000;
	localparam int TAIL_CYCLES = 1100;
	localparam int SETTLE      = 8;
	// phase in which the result side holds off long enough to back up the input
	localparam int HOLD_PHASE  = 2;
	localparam int PHASES      = 14;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic                func;
	logic [ID_W-1:0]     id;
	logic                out_valid;
	logic                out_ready;
	logic [CFG_W-1:0]    position;
	logic [CFG_W-1:0]    min_distance;
	logic                infinite;
	logic                meets_threshold;
	logic [STAT_W-1:0]   status;

	int errors;
	int outstanding;
	int cycle_count = 0;
	int send_quiet = 0;
	logic hold_ready = 1'b0;

	// ids that were sent an arrive and not yet a leave
	logic [ID_W-1:0] seated_pool [$];

	// random phases: row size, threshold, number of words
	// 2047 acts as the full row, 0 is a row with no slots
	int phase_slots [PHASES] = '{5, 2047, 16, 1, 3, 40, 0, 9, 200, 7, 2, 64, 1024, 11};
	int phase_req   [PHASES] = '{1, 300, 2, 0, 2047, 1, 0, 2, 1, 0, 1, 1025, 1, 0};
	int phase_items [PHASES] = '{50, 15, 60, 30, 40, 60, 20, 50, 40, 50, 40, 50, 20, 40};

	max_gap_slot_allocator u_dut (.*);

	max_gap_slot_allocator_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("max_gap_slot_allocator_test failed");
			$finish;
		end
	end

	// one request word: random gap first, unless in a quiet stretch,
	// then hold valid and payload until the handshake
	task automatic offer(input logic f, input logic [ID_W-1:0] rid);
		int gap;
		if (send_quiet > 0) begin
			send_quiet--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 16);
			if ($urandom_range(0, 19) == 0) begin
				send_quiet = $urandom_range(10, 40);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		id <= rid;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// stop offering and wait for every owed result word
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// setup phase then access phase, pready is tied high; then back to idle
	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_row(input logic [CFG_W-1:0] slots, input logic [CFG_W-1:0] req);
		wait_idle();
		write_reg(REG_NUM_SLOTS, slots);
		write_reg(REG_MIN_REQ, req);
	endtask

	// result side: random stall per word, quiet stretches, and one long hold
	initial begin
		int stall;
		int recv_quiet;
		recv_quiet = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_ready) begin
				hold_ready = 1'b0;
				stall = HOLD_CYCLES;
			end else if (recv_quiet > 0) begin
				recv_quiet--;
				stall = 0;
			end else begin
				stall = $urandom_range(0, 16);
				if ($urandom_range(0, 19) == 0) begin
					recv_quiet = $urandom_range(10, 40);
				end
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		int pick;
		int slot;
		logic [ID_W-1:0] rid;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_ARRIVE;
		id <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// full row at reset values, distance still infinite
		offer(FUNC_LEAVE, 10'd5);       // nobody seated yet
		offer(FUNC_ARRIVE, 10'd1023);   // middle of the row
		offer(FUNC_ARRIVE, 10'd1023);   // seated id moves, old seat stays taken
		offer(FUNC_LEAVE, 10'd1023);
		offer(FUNC_LEAVE, 10'd1023);    // already left

		// row with no slots, threshold at its top
		set_row(11'd0, 11'd2047);
		offer(FUNC_ARRIVE, 10'd0);
		offer(FUNC_LEAVE, 10'd0);

		// slot count above the table acts as the full table
		set_row(11'd2047, 11'd1025);
		offer(FUNC_ARRIVE, 10'h2aa);
		offer(FUNC_ARRIVE, 10'h155);

		// single slot: fills at once, seats above the row still free on leave
		set_row(11'd1, 11'd256);
		offer(FUNC_ARRIVE, 10'd7);
		offer(FUNC_ARRIVE, 10'd8);      // row full
		offer(FUNC_LEAVE, 10'h2aa);     // seat beyond the row
		offer(FUNC_LEAVE, 10'd7);
		offer(FUNC_ARRIVE, 10'd9);

		// two slots: neighbours at distance one, then full again
		set_row(11'd2, 11'd1);
		offer(FUNC_ARRIVE, 10'd10);
		offer(FUNC_ARRIVE, 10'd11);
		offer(FUNC_LEAVE, 10'd9);
		offer(FUNC_LEAVE, 10'h155);     // seat beyond the row

		// random phases: mostly arrive and leave of ids we seated, some noise
		for (int p = 0; p < PHASES; p++) begin
			set_row(CFG_W'(phase_slots[p]), CFG_W'(phase_req[p]));
			if (p == HOLD_PHASE) begin
				hold_ready = 1'b1;
			end
			for (int k = 0; k < phase_items[p]; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					if (seated_pool.size() != 0 && $urandom_range(0, 4) == 0) begin
						rid = seated_pool[$urandom_range(0, seated_pool.size() - 1)];
					end else begin
						rid = ID_W'($urandom_range(0, MAX_IDS - 1));
					end
					seated_pool.push_back(rid);
					offer(FUNC_ARRIVE, rid);
				end else if (pick < 90 && seated_pool.size() != 0) begin
					slot = $urandom_range(0, seated_pool.size() - 1);
					rid = seated_pool[slot];
					seated_pool.delete(slot);
					offer(FUNC_LEAVE, rid);
				end else begin
					offer(FUNC_LEAVE, ID_W'($urandom_range(0, MAX_IDS - 1)));
				end
			end
		end

		// drain, then give a stray word time to show up
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("max_gap_slot_allocator_test passed");
		end else begin
			$display("max_gap_slot_allocator_test failed");
		end
		$finish;
	end

endmodule
